// ===== sv/vtm_pkg.sv =====
package vtm_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP,
        ST_PERIOD,
        ST_READ,
        ST_MATCH,
        ST_FIRE,
        ST_SCAN,
        ST_SPENT,
        ST_GUARD,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_TICK        = 4'd0,
        OP_GEN_SCHED   = 4'd1,
        OP_GEN_CANCEL  = 4'd2,
        OP_RADIO_START = 4'd3,
        OP_SET_PERIOD  = 4'd4,
        OP_CMP_SCHED   = 4'd5,
        OP_CMP_CANCEL  = 4'd6,
        OP_RD_GEN      = 4'd7,
        OP_RD_OVF      = 4'd8,
        OP_RD_PERIOD   = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        KIND_ACK  = 2'd0,
        KIND_FIRE = 2'd1,
        KIND_READ = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        SRC_GEN = 2'd0,
        SRC_OVF = 2'd1,
        SRC_CMP = 2'd2
    } t_src;

    localparam logic [7:0]  GUARD_RESET = 8'd4;
    localparam logic [15:0] WRAP_LIMIT  = 16'd65000;
    localparam logic [3:0]  MAX_RESULTS = 4'd10;

    typedef struct packed {
        t_kind       kind;
        t_src        src;
        logic [15:0] data;
    } t_result;

endpackage

// ===== sv/virtual_timer_multiplexer.sv =====
// Commands run a three-entry scan of the armed timers through one shared 16-bit
// adder/subtractor. A tick with a match fires each matched timer, then may run late
// rounds, bounded by MAX_LATE_ROUNDS and by MAX_RESULTS fired results.
// One word in flight at a time; s_axis_tready is high only while idle.
// Results leave through an output register, so the next word can enter while
// the final result waits. Reset (sync, active low) clears all timer state and
// sets guard_ticks to 4.
module virtual_timer_multiplexer #(
    parameter int MAX_LATE_ROUNDS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,   // guard_ticks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [15:0] value
    input  logic [3:0]  s_axis_tuser,    // [3:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // [15:0] data, [16] overrun, zero pad
    output logic [3:0]  m_axis_tuser,    // [1:0] kind, [3:2] source
    output logic        m_axis_tlast
);

    localparam int RW = $clog2(MAX_LATE_ROUNDS + 1);

    vtm_pkg::t_state r_state, n_state;

    // timer state
    logic [7:0]  r_guard;
    logic [15:0] r_counter, r_cur_time, r_next_load;
    logic        r_running;
    logic [2:0]  r_armed;
    logic [15:0] r_cv [3];
    logic [15:0] r_period, r_prev_ovf, r_cmp_off, r_gen_total;

    // item and work registers
    vtm_pkg::t_op r_op;
    logic [15:0] r_value, r_tmp, r_spent, r_best, r_load;
    logic [2:0]  r_mask;
    logic [3:0]  r_n;
    logic [RW-1:0] r_rounds;
    logic        r_over, r_late, r_in_match, r_found;
    logic [1:0]  r_idx, r_pick;

    // result staging: held back one step so the final one can carry last/overrun
    vtm_pkg::t_result r_pend;
    logic        r_pend_v;
    vtm_pkg::t_result r_out;
    logic        r_out_v, r_out_last, r_out_over;

    // shared adder
    logic [15:0] add_a, add_b, sum;
    logic        add_sub;

    logic        out_free, fire_ok, take, scan_last, found_n, match_hit, tick_match;
    logic [15:0] load_n;
    logic [1:0]  pick_n;
    logic [2:0]  match_mask, mask_rest;
    vtm_pkg::t_src fire_src;
    logic [15:0] fire_data;
    logic        bound_hit;

    assign sum = add_a + (add_sub ? ~add_b : add_b) + {15'd0, add_sub};

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (r_state)
            vtm_pkg::ST_DISP: begin
                case (r_op)
                    vtm_pkg::OP_TICK: begin
                        add_a = r_counter;
                        add_b = 16'd1;
                    end
                    vtm_pkg::OP_GEN_SCHED: begin
                        add_a = r_cv[0];
                        add_b = r_value;
                    end
                    vtm_pkg::OP_RADIO_START: begin
                        add_a = r_cv[1];
                        add_b = r_value;
                    end
                    vtm_pkg::OP_SET_PERIOD: begin
                        add_a = r_value;
                        add_b = 16'd1;
                    end
                    vtm_pkg::OP_CMP_SCHED: begin
                        add_a = r_prev_ovf;
                        add_b = r_value;
                    end
                    vtm_pkg::OP_RD_GEN: begin
                        add_a   = r_cv[0];
                        add_b   = r_counter;
                        add_sub = 1'b1;
                    end
                    vtm_pkg::OP_RD_OVF: begin
                        add_a   = r_counter;
                        add_b   = r_prev_ovf;
                        add_sub = 1'b1;
                    end
                    default: ;
                endcase
            end
            vtm_pkg::ST_PERIOD: begin
                add_a = r_prev_ovf;
                add_b = r_period;
            end
            vtm_pkg::ST_READ: begin
                add_a   = r_gen_total;
                add_b   = r_tmp;
                add_sub = 1'b1;
            end
            vtm_pkg::ST_FIRE: begin
                add_a = r_cv[1];
                add_b = r_mask[1] ? r_period : r_cmp_off;
            end
            vtm_pkg::ST_SCAN: begin
                add_a   = r_cv[r_idx];
                add_b   = r_cur_time;
                add_sub = 1'b1;
            end
            vtm_pkg::ST_SPENT: begin
                add_a   = r_counter;
                add_b   = r_cur_time;
                add_sub = 1'b1;
            end
            vtm_pkg::ST_GUARD: begin
                add_a = r_spent;
                add_b = {8'd0, r_guard};
            end
            default: ;
        endcase
    end

    always_comb begin
        out_free   = !r_out_v || m_axis_tready;
        fire_ok    = !r_pend_v || out_free;
        tick_match = r_running && (sum == r_next_load);
        // scan step: nearest armed timer; in late mode only those inside spent
        take       = r_armed[r_idx] && (!r_late || (r_spent > sum))
                     && (!r_found || (sum < r_best));
        scan_last  = (r_idx == 2'd2);
        found_n    = r_found || take;
        load_n     = take ? r_cv[r_idx] : r_load;
        pick_n     = take ? r_idx : r_pick;
        bound_hit  = (r_rounds >= RW'(MAX_LATE_ROUNDS)) || (r_n >= vtm_pkg::MAX_RESULTS);
        for (int i = 0; i < 3; i++) begin
            match_mask[i] = r_armed[i] && (r_cv[i] == r_next_load);
        end
        if (match_mask[1]) begin
            match_mask[2] = 1'b0;  // overflow suppresses compare
        end
        match_hit = |match_mask;
        if (r_mask[1]) begin
            fire_src  = vtm_pkg::SRC_OVF;
            fire_data = r_cv[1];
            mask_rest = r_mask & 3'b101;
        end else if (r_mask[2]) begin
            fire_src  = vtm_pkg::SRC_CMP;
            fire_data = r_cv[2];
            mask_rest = r_mask & 3'b011;
        end else begin
            fire_src  = vtm_pkg::SRC_GEN;
            fire_data = r_cv[0];
            mask_rest = 3'b000;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vtm_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = vtm_pkg::ST_DISP;
                end
            end
            vtm_pkg::ST_DISP: begin
                case (r_op)
                    vtm_pkg::OP_TICK:
                        n_state = tick_match ? vtm_pkg::ST_MATCH : vtm_pkg::ST_DONE;
                    vtm_pkg::OP_GEN_SCHED, vtm_pkg::OP_GEN_CANCEL,
                    vtm_pkg::OP_RADIO_START, vtm_pkg::OP_CMP_SCHED,
                    vtm_pkg::OP_CMP_CANCEL:
                        n_state = vtm_pkg::ST_SCAN;
                    vtm_pkg::OP_SET_PERIOD:
                        n_state = vtm_pkg::ST_PERIOD;
                    vtm_pkg::OP_RD_GEN:
                        n_state = vtm_pkg::ST_READ;
                    default:
                        n_state = vtm_pkg::ST_DONE;
                endcase
            end
            vtm_pkg::ST_PERIOD: n_state = vtm_pkg::ST_SCAN;
            vtm_pkg::ST_READ:   n_state = vtm_pkg::ST_DONE;
            vtm_pkg::ST_MATCH:  n_state = match_hit ? vtm_pkg::ST_FIRE : vtm_pkg::ST_SCAN;
            vtm_pkg::ST_FIRE: begin
                if (fire_ok && (mask_rest == 3'b000)) begin
                    n_state = vtm_pkg::ST_SCAN;
                end
            end
            vtm_pkg::ST_SCAN: begin
                if (scan_last) begin
                    if (!r_late) begin
                        n_state = r_in_match ? vtm_pkg::ST_SPENT : vtm_pkg::ST_DONE;
                    end else if (!found_n || bound_hit) begin
                        n_state = vtm_pkg::ST_DONE;
                    end else begin
                        n_state = vtm_pkg::ST_FIRE;
                    end
                end
            end
            vtm_pkg::ST_SPENT: n_state = vtm_pkg::ST_GUARD;
            vtm_pkg::ST_GUARD: n_state = vtm_pkg::ST_SCAN;
            vtm_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = vtm_pkg::ST_IDLE;
                end
            end
            default: n_state = vtm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vtm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guard     <= vtm_pkg::GUARD_RESET;
            r_counter   <= '0;
            r_cur_time  <= '0;
            r_next_load <= '0;
            r_running   <= 1'b0;
            r_armed     <= '0;
            r_cv[0]     <= '0;
            r_cv[1]     <= '0;
            r_cv[2]     <= '0;
            r_period    <= '0;
            r_prev_ovf  <= '0;
            r_cmp_off   <= '0;
            r_gen_total <= '0;
            r_pend_v    <= 1'b0;
            r_out_v     <= 1'b0;
            r_over      <= 1'b0;
            r_late      <= 1'b0;
            r_in_match  <= 1'b0;
            r_found     <= 1'b0;
            r_idx       <= '0;
            r_n         <= '0;
            r_rounds    <= '0;
            r_mask      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_guard <= i_cfg_wr_data;
            end
            if (r_out_v && m_axis_tready) begin
                r_out_v <= 1'b0;
            end

            unique case (r_state)
                vtm_pkg::ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op       <= vtm_pkg::t_op'(s_axis_tuser);
                        r_value    <= s_axis_tdata;
                        r_over     <= 1'b0;
                        r_late     <= 1'b0;
                        r_in_match <= 1'b0;
                        r_found    <= 1'b0;
                        r_idx      <= '0;
                    end
                end
                vtm_pkg::ST_DISP: begin
                    r_pend_v <= 1'b1;
                    r_pend   <= '{vtm_pkg::KIND_ACK, vtm_pkg::SRC_GEN, 16'd0};
                    case (r_op)
                        vtm_pkg::OP_TICK: begin
                            r_counter <= sum;
                            if (tick_match) begin
                                r_pend_v <= 1'b0;
                            end
                        end
                        vtm_pkg::OP_GEN_SCHED: begin
                            r_gen_total <= r_value;
                            r_cv[0]     <= sum;
                            r_armed[0]  <= 1'b1;
                        end
                        vtm_pkg::OP_GEN_CANCEL: begin
                            r_gen_total <= '0;
                            r_cv[0]     <= '0;
                            r_armed[0]  <= 1'b0;
                        end
                        vtm_pkg::OP_RADIO_START: begin
                            r_period   <= r_value;
                            r_prev_ovf <= r_cv[1];
                            r_cv[1]    <= sum;
                            r_armed[1] <= 1'b1;
                        end
                        vtm_pkg::OP_SET_PERIOD: begin
                            r_period <= sum;
                        end
                        vtm_pkg::OP_CMP_SCHED: begin
                            r_cmp_off  <= r_value;
                            r_cv[2]    <= sum;
                            r_armed[2] <= 1'b1;
                        end
                        vtm_pkg::OP_CMP_CANCEL: begin
                            r_armed[2] <= 1'b0;
                        end
                        vtm_pkg::OP_RD_GEN: begin
                            r_tmp <= sum;
                        end
                        vtm_pkg::OP_RD_OVF: begin
                            r_pend <= '{vtm_pkg::KIND_READ, vtm_pkg::SRC_OVF, sum};
                        end
                        vtm_pkg::OP_RD_PERIOD: begin
                            r_pend <= '{vtm_pkg::KIND_READ, vtm_pkg::SRC_OVF, r_period};
                        end
                        default: ;
                    endcase
                end
                vtm_pkg::ST_PERIOD: begin
                    r_cv[1] <= sum;
                end
                vtm_pkg::ST_READ: begin
                    r_pend <= '{vtm_pkg::KIND_READ, vtm_pkg::SRC_GEN, sum};
                end
                vtm_pkg::ST_MATCH: begin
                    r_cur_time <= r_next_load;
                    r_mask     <= match_mask;
                    r_in_match <= match_hit;
                    r_n        <= '0;
                    r_rounds   <= '0;
                    if (!match_hit) begin
                        // spurious match: reschedule and acknowledge
                        r_pend_v <= 1'b1;
                    end
                end
                vtm_pkg::ST_FIRE: begin
                    if (fire_ok) begin
                        if (r_pend_v) begin
                            r_out      <= r_pend;
                            r_out_v    <= 1'b1;
                            r_out_last <= 1'b0;
                            r_out_over <= 1'b0;
                        end
                        r_pend_v <= 1'b1;
                        r_pend   <= '{vtm_pkg::KIND_FIRE, fire_src, fire_data};
                        r_n      <= r_n + 4'd1;
                        r_mask   <= mask_rest;
                        case (fire_src)
                            vtm_pkg::SRC_OVF: begin
                                r_prev_ovf <= r_cv[1];
                                r_cv[1]    <= sum;
                            end
                            vtm_pkg::SRC_CMP: r_cv[2] <= sum;
                            default:          r_armed[0] <= 1'b0;
                        endcase
                        r_late  <= 1'b0;
                        r_found <= 1'b0;
                        r_idx   <= '0;
                    end
                end
                vtm_pkg::ST_SCAN: begin
                    r_idx   <= r_idx + 2'd1;
                    r_found <= found_n;
                    if (take) begin
                        r_best <= sum;
                        r_load <= r_cv[r_idx];
                        r_pick <= r_idx;
                    end
                    if (scan_last) begin
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        if (!r_late) begin
                            r_running <= found_n;
                            if (found_n) begin
                                r_next_load <= load_n;
                            end
                        end else if (found_n) begin
                            if (bound_hit) begin
                                r_over <= 1'b1;
                            end else begin
                                r_rounds    <= r_rounds + RW'(1);
                                r_mask      <= 3'b001 << pick_n;
                                r_cur_time  <= r_counter;
                                r_next_load <= r_counter;
                            end
                        end
                    end
                end
                vtm_pkg::ST_SPENT: begin
                    r_spent <= sum;
                end
                vtm_pkg::ST_GUARD: begin
                    // elapsed plus guard past the wrap limit counts as guard only
                    r_spent <= (sum > vtm_pkg::WRAP_LIMIT) ? {8'd0, r_guard} : sum;
                    r_late  <= 1'b1;
                    r_found <= 1'b0;
                    r_idx   <= '0;
                end
                vtm_pkg::ST_DONE: begin
                    if (out_free) begin
                        r_out      <= r_pend;
                        r_out_v    <= 1'b1;
                        r_out_last <= 1'b1;
                        r_out_over <= r_over;
                        r_pend_v   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == vtm_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {7'd0, r_out_over, r_out.data};
    assign m_axis_tuser  = {r_out.src, r_out.kind};
    assign m_axis_tlast  = r_out_last;

endmodule
